@@ rtl/core/tcd_pkg.sv @@
// Shared constants for the triangle conformal distortion block.
package tcd_pkg;

   // Default word width and fraction width (Q16.16)
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

endpackage

@@ rtl/core/tcd_if.sv @@
// Valid/ready channel interfaces for triangle items and distortion results.
interface tcd_req_if import tcd_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] edge1_x;
   logic signed [DATA_WIDTH-1:0] edge1_y;
   logic signed [DATA_WIDTH-1:0] edge1_z;
   logic signed [DATA_WIDTH-1:0] edge2_x;
   logic signed [DATA_WIDTH-1:0] edge2_y;
   logic signed [DATA_WIDTH-1:0] edge2_z;
   logic signed [DATA_WIDTH-1:0] tex1_du;
   logic signed [DATA_WIDTH-1:0] tex1_dv;
   logic signed [DATA_WIDTH-1:0] tex2_du;
   logic signed [DATA_WIDTH-1:0] tex2_dv;

   modport source (
      output valid, edge1_x, edge1_y, edge1_z, edge2_x, edge2_y, edge2_z,
             tex1_du, tex1_dv, tex2_du, tex2_dv,
      input  ready
   );
   modport sink (
      input  valid, edge1_x, edge1_y, edge1_z, edge2_x, edge2_y, edge2_z,
             tex1_du, tex1_dv, tex2_du, tex2_dv,
      output ready
   );
endinterface

interface tcd_rsp_if import tcd_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] conf_re;
   logic signed [DATA_WIDTH-1:0] conf_im;
   logic signed [DATA_WIDTH-1:0] anticonf_re;
   logic signed [DATA_WIDTH-1:0] anticonf_im;
   logic        [DATA_WIDTH-1:0] distortion;
   logic                         degenerate_tri;
   logic                         flipped_map;

   modport source (
      output valid, conf_re, conf_im, anticonf_re, anticonf_im, distortion,
             degenerate_tri, flipped_map,
      input  ready
   );
   modport sink (
      input  valid, conf_re, conf_im, anticonf_re, anticonf_im, distortion,
             degenerate_tri, flipped_map,
      output ready
   );
endinterface

@@ rtl/core/tcd_delay.sv @@
// Stallable delay line for payload that waits alongside the arithmetic units.
module tcd_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
)(
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   // shift one place per advancing cycle
   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign q = tap_ff[DEPTH-1];

endmodule

@@ rtl/core/tcd_mul.sv @@
// Two-stage unsigned multiplier built from CW x CW partial products.
module tcd_mul #(
   parameter int CW = 32,
   parameter int AW = 32,
   parameter int BW = 64
)(
   input  logic             clock,
   input  logic             en,
   input  logic [AW-1:0]    a,
   input  logic [BW-1:0]    b,
   output logic [AW+BW-1:0] p
);

   localparam int NA = (AW + CW - 1) / CW;
   localparam int NB = (BW + CW - 1) / CW;
   localparam int AE = NA * CW;
   localparam int BE = NB * CW;
   localparam int PP = 2 * CW;
   localparam int SW = AE + BE;

   logic [AE-1:0]     a_ext;
   logic [BE-1:0]     b_ext;
   logic [PP-1:0]     pp_ff [NA][NB];
   logic [SW-1:0]     sum_in;
   logic [AW+BW-1:0]  p_ff;

   assign a_ext = AE'(a);
   assign b_ext = BE'(b);

   // stage 1: partial products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i][j] <= PP'(a_ext[i*CW +: CW]) * PP'(b_ext[j*CW +: CW]);
            end
         end
      end
   end

   // stage 2: weighted sum of the partial products
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            sum_in = sum_in + (SW'(pp_ff[i][j]) << (CW * (i + j)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= sum_in[AW+BW-1:0];
      end
   end

   assign p = p_ff;

endmodule

@@ rtl/core/tcd_sqrt.sv @@
// Pipelined floor square root, one result bit per stage.
module tcd_sqrt #(
   parameter int IW = 64
)(
   input  logic            clock,
   input  logic            en,
   input  logic [IW-1:0]   x,
   output logic [IW/2-1:0] root
);

   localparam int RW = IW / 2;

   logic [IW-1:0] rem_ff  [RW];
   logic [RW-1:0] root_ff [RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      localparam int B = RW - 1 - k;
      logic [IW-1:0] rem_i;
      logic [RW-1:0] root_i;
      logic [IW:0]   trial;

      if (k == 0) begin : g_first
         assign rem_i  = x;
         assign root_i = '0;
      end else begin : g_next
         assign rem_i  = rem_ff[k-1];
         assign root_i = root_ff[k-1];
      end

      // (root + 2^B)^2 - root^2
      assign trial = ((IW+1)'(root_i) << (B + 1)) + ((IW+1)'(1) << (2 * B));

      always_ff @(posedge clock) begin
         if (en) begin
            if ({1'b0, rem_i} >= trial) begin
               rem_ff[k]  <= rem_i - trial[IW-1:0];
               root_ff[k] <= root_i | (RW'(1) << B);
            end else begin
               rem_ff[k]  <= rem_i;
               root_ff[k] <= root_i;
            end
         end
      end
   end

   assign root = root_ff[RW-1];

endmodule

@@ rtl/core/tcd_div.sv @@
// Pipelined restoring divider: overflow check, then one quotient bit per stage.
module tcd_div #(
   parameter int NW = 64,
   parameter int DW = 32,
   parameter int QW = 32
)(
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quot,
   output logic          ovf
);

   localparam int XW = (NW > DW + QW) ? NW : DW + QW;

   logic [NW-1:0] rem_ff [QW+1];
   logic [DW-1:0] den_ff [QW+1];
   logic [QW-1:0] q_ff   [QW+1];
   logic          ovf_ff [QW+1];

   // quotient does not fit in QW bits
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num;
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         ovf_ff[0] <= XW'(num) >= (XW'(den) << QW);
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_stage
      localparam int B = QW - 1 - k;
      logic [XW-1:0] sub;

      assign sub = XW'(den_ff[k]) << B;

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k+1] <= den_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
            if (XW'(rem_ff[k]) >= sub) begin
               rem_ff[k+1] <= rem_ff[k] - sub[NW-1:0];
               q_ff[k+1]   <= q_ff[k] | (QW'(1) << B);
            end else begin
               rem_ff[k+1] <= rem_ff[k];
               q_ff[k+1]   <= q_ff[k];
            end
         end
      end
   end

   assign quot = q_ff[QW];
   assign ovf  = ovf_ff[QW];

endmodule

@@ rtl/core/triangle_conformal_distortion.sv @@
// Triangle conformal distortion: fully pipelined Jacobian split and distortion ratio.
//
//   channel  | dir | handshake    | item
//   ---------+-----+--------------+-------------------------------------------
//   req_if   | in  | valid/ready  | two 3D edges and two texture edges, Q16.16
//   rsp_if   | out | valid/ready  | alpha, beta, distortion, two flags
//
// One triangle enters per cycle while the output is not stalled. The pipeline depth
// is set by the bit-per-stage square roots and dividers (Q16.16 by default).
// Reset clears the valid bits only; no state is kept between items.
// A stall at the output holds the whole pipeline; nothing is lost or repeated.
module triangle_conformal_distortion import tcd_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
)(
   input  logic      clock,
   input  logic      reset,
   tcd_req_if.sink   req_if,
   tcd_rsp_if.source rsp_if
);

   localparam int W   = DATA_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int W2  = 2 * W;
   localparam int W3  = 3 * W;
   localparam int W4  = 4 * W;
   localparam int CNW = W3 + F + 2;     // coefficient dividend
   localparam int RW2 = W + F;          // |alpha|, |beta|
   localparam int DNW = W + 2 * F + 2;  // distortion dividend

   localparam int T_A   = 6 + W2;
   localparam int T_Q   = T_A + 8 + W;
   localparam int T_R   = T_Q + 3 + RW2;
   localparam int T_Z   = T_R + 3 + W;
   localparam int T_OUT = T_Z + 1;

   localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] ONE_Q   = W'(1) << F;

   // pipeline advance and valid bits
   logic             en;
   logic [T_OUT-1:0] vld_ff;

   assign en           = !vld_ff[T_OUT-1] || rsp_if.ready;
   assign req_if.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[T_OUT-2:0], req_if.valid};
      end
   end

   // stage 1: edge products
   logic signed [W2-1:0] pc_ff [6];
   logic signed [W2-1:0] pg_ff [3];
   logic signed [W2-1:0] ph_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         pc_ff[0] <= req_if.edge1_y * req_if.edge2_z;
         pc_ff[1] <= req_if.edge1_z * req_if.edge2_y;
         pc_ff[2] <= req_if.edge1_z * req_if.edge2_x;
         pc_ff[3] <= req_if.edge1_x * req_if.edge2_z;
         pc_ff[4] <= req_if.edge1_x * req_if.edge2_y;
         pc_ff[5] <= req_if.edge1_y * req_if.edge2_x;
         pg_ff[0] <= req_if.edge1_x * req_if.edge1_x;
         pg_ff[1] <= req_if.edge1_y * req_if.edge1_y;
         pg_ff[2] <= req_if.edge1_z * req_if.edge1_z;
         ph_ff[0] <= req_if.edge1_x * req_if.edge2_x;
         ph_ff[1] <= req_if.edge1_y * req_if.edge2_y;
         ph_ff[2] <= req_if.edge1_z * req_if.edge2_z;
      end
   end

   // stage 2: cross product, |e1|^2, e1.e2
   logic [W2:0]   c_ff [3];
   logic [W2-1:0] g2_ff;
   logic [W2+1:0] h2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            c_ff[i] <= {pc_ff[2*i][W2-1], pc_ff[2*i]} - {pc_ff[2*i+1][W2-1], pc_ff[2*i+1]};
         end
         g2_ff <= pg_ff[0][W2-1:0] + pg_ff[1][W2-1:0] + pg_ff[2][W2-1:0];
         h2_ff <= {{2{ph_ff[0][W2-1]}}, ph_ff[0]} + {{2{ph_ff[1][W2-1]}}, ph_ff[1]}
                + {{2{ph_ff[2][W2-1]}}, ph_ff[2]};
      end
   end

   // stage 3: magnitudes
   logic [W2-1:0] ac_ff [3];
   logic [W2-1:0] g3_ff;
   logic [W2-1:0] hm3_ff;
   logic          hneg3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            ac_ff[i] <= c_ff[i][W2] ? W2'(-c_ff[i]) : c_ff[i][W2-1:0];
         end
         g3_ff    <= g2_ff;
         hm3_ff   <= h2_ff[W2+1] ? W2'(-h2_ff) : h2_ff[W2-1:0];
         hneg3_ff <= h2_ff[W2+1];
      end
   end

   // squared cross components and their sum
   logic [W4-1:0] csq [3];
   logic [W4-1:0] c2_ff;

   for (genvar i = 0; i < 3; i++) begin : g_csq
      tcd_mul #(.CW(W), .AW(W2), .BW(W2)) u_mul (
         .clock (clock), .en (en), .a (ac_ff[i]), .b (ac_ff[i]), .p (csq[i])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c2_ff <= csq[0] + csq[1] + csq[2];
      end
   end

   // area determinant and edge length
   logic [W2-1:0] a_root;
   logic [W-1:0]  l_root;
   logic [W-1:0]  l_ta;
   logic [W2-1:0] g_ta;
   logic [W2-1:0] hm_ta;
   logic          hneg_ta;

   tcd_sqrt #(.IW(W4)) u_sqrt_area (.clock (clock), .en (en), .x (c2_ff), .root (a_root));
   tcd_sqrt #(.IW(W2)) u_sqrt_len  (.clock (clock), .en (en), .x (g3_ff), .root (l_root));

   tcd_delay #(.WIDTH(W), .DEPTH(T_A - 3 - W)) u_dly_len (
      .clock (clock), .en (en), .d (l_root), .q (l_ta)
   );
   tcd_delay #(.WIDTH(2 * W2 + 1), .DEPTH(T_A - 3)) u_dly_gh (
      .clock (clock), .en (en), .d ({g3_ff, hm3_ff, hneg3_ff}), .q ({g_ta, hm_ta, hneg_ta})
   );

   // texture deltas as sign and magnitude
   logic [W-1:0] tm_in [4];
   logic [3:0]   ts_in;
   logic [W-1:0] tm_ta [4];
   logic [3:0]   ts_ta;

   always_comb begin
      ts_in    = {req_if.tex2_dv[W-1], req_if.tex2_du[W-1],
                  req_if.tex1_dv[W-1], req_if.tex1_du[W-1]};
      tm_in[0] = ts_in[0] ? W'(-req_if.tex1_du) : W'(req_if.tex1_du);
      tm_in[1] = ts_in[1] ? W'(-req_if.tex1_dv) : W'(req_if.tex1_dv);
      tm_in[2] = ts_in[2] ? W'(-req_if.tex2_du) : W'(req_if.tex2_du);
      tm_in[3] = ts_in[3] ? W'(-req_if.tex2_dv) : W'(req_if.tex2_dv);
   end

   tcd_delay #(.WIDTH(4 * W + 4), .DEPTH(T_A)) u_dly_tex (
      .clock (clock), .en (en),
      .d ({ts_in, tm_in[3], tm_in[2], tm_in[1], tm_in[0]}),
      .q ({ts_ta, tm_ta[3], tm_ta[2], tm_ta[1], tm_ta[0]})
   );

   // Jacobian numerator products: u1*A, v1*A, u2*G, u1*|H|, v2*G, v1*|H|, L*A
   logic [W-1:0]  ma [7];
   logic [W2-1:0] mb [7];
   logic [W3-1:0] mp [7];
   logic [4:0]    msg;

   assign ma[0] = tm_ta[0];  assign mb[0] = a_root;
   assign ma[1] = tm_ta[1];  assign mb[1] = a_root;
   assign ma[2] = tm_ta[2];  assign mb[2] = g_ta;
   assign ma[3] = tm_ta[0];  assign mb[3] = hm_ta;
   assign ma[4] = tm_ta[3];  assign mb[4] = g_ta;
   assign ma[5] = tm_ta[1];  assign mb[5] = hm_ta;
   assign ma[6] = l_ta;      assign mb[6] = a_root;

   for (genvar i = 0; i < 7; i++) begin : g_jmul
      tcd_mul #(.CW(W), .AW(W), .BW(W2)) u_mul (
         .clock (clock), .en (en), .a (ma[i]), .b (mb[i]), .p (mp[i])
      );
   end

   tcd_delay #(.WIDTH(5), .DEPTH(2)) u_dly_sgn (
      .clock (clock), .en (en), .d ({hneg_ta, ts_ta}), .q (msg)
   );

   // N1: signed products
   logic [W3:0] sp_ff [6];
   logic [5:0]  sneg;

   assign sneg = {msg[1] ^ msg[4], msg[3], msg[0] ^ msg[4], msg[2], msg[1], msg[0]};

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 6; i++) begin
            sp_ff[i] <= sneg[i] ? -{1'b0, mp[i]} : {1'b0, mp[i]};
         end
      end
   end

   // N2: Na, Nb, Nc, Nd
   logic [W3+1:0] na_ff, nb_ff, nc_ff, nd_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         na_ff <= {sp_ff[0][W3], sp_ff[0]};
         nc_ff <= {sp_ff[1][W3], sp_ff[1]};
         nb_ff <= {sp_ff[2][W3], sp_ff[2]} - {sp_ff[3][W3], sp_ff[3]};
         nd_ff <= {sp_ff[4][W3], sp_ff[4]} - {sp_ff[5][W3], sp_ff[5]};
      end
   end

   // N3: alpha and beta numerators
   logic [W3+2:0] k_ff [4];

   always_ff @(posedge clock) begin
      if (en) begin
         k_ff[0] <= {na_ff[W3+1], na_ff} + {nd_ff[W3+1], nd_ff};
         k_ff[1] <= {nc_ff[W3+1], nc_ff} - {nb_ff[W3+1], nb_ff};
         k_ff[2] <= {na_ff[W3+1], na_ff} - {nd_ff[W3+1], nd_ff};
         k_ff[3] <= {nb_ff[W3+1], nb_ff} + {nc_ff[W3+1], nc_ff};
      end
   end

   // N4: sign and magnitude
   logic [W3+1:0] kmag_ff [4];
   logic [3:0]    kneg_ff;
   logic [W3-1:0] d_n4;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            kneg_ff[i] <= k_ff[i][W3+2];
            kmag_ff[i] <= k_ff[i][W3+2] ? (W3+2)'(-k_ff[i]) : k_ff[i][W3+1:0];
         end
      end
   end

   tcd_delay #(.WIDTH(W3), .DEPTH(4)) u_dly_den (
      .clock (clock), .en (en), .d (mp[6]), .q (d_n4)
   );

   // N5: rounded dividend |N| * 2^(F-1) + D/2
   logic [CNW-1:0] cnum_ff [4];
   logic [W3-1:0]  cden_ff;
   logic [3:0]     cneg_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            cnum_ff[i] <= (CNW'(kmag_ff[i]) << (F - 1)) + CNW'(d_n4 >> 1);
         end
         cden_ff <= d_n4;
         cneg_ff <= kneg_ff;
      end
   end

   // coefficient dividers
   logic [W-1:0] cq [4];
   logic [3:0]   covf;
   logic [3:0]   cneg_q;

   for (genvar i = 0; i < 4; i++) begin : g_cdiv
      tcd_div #(.NW(CNW), .DW(W3), .QW(W)) u_div (
         .clock (clock), .en (en), .num (cnum_ff[i]), .den (cden_ff),
         .quot (cq[i]), .ovf (covf[i])
      );
   end

   tcd_delay #(.WIDTH(4), .DEPTH(W + 1)) u_dly_cneg (
      .clock (clock), .en (en), .d (cneg_ff), .q (cneg_q)
   );

   // C1: saturate and restore sign
   logic [W-1:0] cm_ff [4];
   logic [W-1:0] co_ff [4];
   logic [W-1:0] lim   [4];
   logic [W-1:0] sat   [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         lim[i] = cneg_q[i] ? LIM_NEG : LIM_POS;
         sat[i] = (covf[i] || cq[i] > lim[i]) ? lim[i] : cq[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            cm_ff[i] <= sat[i];
            co_ff[i] <= cneg_q[i] ? -sat[i] : sat[i];
         end
      end
   end

   // C2, C3: squared moduli scaled to 4F fraction bits
   logic [W2-1:0]      sq_ff [4];
   logic [W2+2*F-1:0]  rad_a_ff, rad_b_ff;
   logic [W2-1:0]      asum, bsum;

   assign asum = sq_ff[0] + sq_ff[1];
   assign bsum = sq_ff[2] + sq_ff[3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            sq_ff[i] <= W2'(cm_ff[i]) * W2'(cm_ff[i]);
         end
         rad_a_ff <= {asum, {(2*F){1'b0}}};
         rad_b_ff <= {bsum, {(2*F){1'b0}}};
      end
   end

   logic [RW2-1:0] am, bm;

   tcd_sqrt #(.IW(W2 + 2 * F)) u_sqrt_a (.clock (clock), .en (en), .x (rad_a_ff), .root (am));
   tcd_sqrt #(.IW(W2 + 2 * F)) u_sqrt_b (.clock (clock), .en (en), .x (rad_b_ff), .root (bm));

   // E1, E2: flip test and rounded ratio dividend
   logic           flip1_ff, flip2_ff;
   logic [RW2-1:0] den1_ff, dden_ff;
   logic [RW2:0]   sum1_ff;
   logic [DNW-1:0] dnum_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         flip1_ff <= am <= bm;
         den1_ff  <= am - bm;
         sum1_ff  <= {1'b0, am} + {1'b0, bm};
         flip2_ff <= flip1_ff;
         dden_ff  <= den1_ff;
         dnum_ff  <= (DNW'(sum1_ff) << F) + DNW'(den1_ff >> 1);
      end
   end

   logic [W-1:0] dq;
   logic         dovf;

   tcd_div #(.NW(DNW), .DW(RW2), .QW(W)) u_div_dist (
      .clock (clock), .en (en), .num (dnum_ff), .den (dden_ff), .quot (dq), .ovf (dovf)
   );

   // side data aligned to the ratio divider output
   logic         flip_z;
   logic         deg_z;
   logic [W-1:0] co_z [4];

   tcd_delay #(.WIDTH(1), .DEPTH(W + 1)) u_dly_flip (
      .clock (clock), .en (en), .d (flip2_ff), .q (flip_z)
   );
   tcd_delay #(.WIDTH(1), .DEPTH(T_Z - 6)) u_dly_deg (
      .clock (clock), .en (en), .d (c2_ff == '0), .q (deg_z)
   );
   tcd_delay #(.WIDTH(4 * W), .DEPTH(T_Z - T_Q - 1)) u_dly_coef (
      .clock (clock), .en (en),
      .d ({co_ff[3], co_ff[2], co_ff[1], co_ff[0]}),
      .q ({co_z[3], co_z[2], co_z[1], co_z[0]})
   );

   // output register
   logic [W-1:0] o_cre_ff, o_cim_ff, o_are_ff, o_aim_ff, o_dist_ff;
   logic         o_deg_ff, o_flip_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (deg_z) begin
            o_cre_ff  <= ONE_Q;
            o_cim_ff  <= '0;
            o_are_ff  <= '0;
            o_aim_ff  <= '0;
            o_dist_ff <= ONE_Q;
            o_deg_ff  <= 1'b1;
            o_flip_ff <= 1'b0;
         end else begin
            o_cre_ff  <= co_z[0];
            o_cim_ff  <= co_z[1];
            o_are_ff  <= co_z[2];
            o_aim_ff  <= co_z[3];
            o_dist_ff <= (flip_z || dovf) ? '1 : dq;
            o_deg_ff  <= 1'b0;
            o_flip_ff <= flip_z;
         end
      end
   end

   assign rsp_if.valid          = vld_ff[T_OUT-1];
   assign rsp_if.conf_re        = o_cre_ff;
   assign rsp_if.conf_im        = o_cim_ff;
   assign rsp_if.anticonf_re    = o_are_ff;
   assign rsp_if.anticonf_im    = o_aim_ff;
   assign rsp_if.distortion     = o_dist_ff;
   assign rsp_if.degenerate_tri = o_deg_ff;
   assign rsp_if.flipped_map    = o_flip_ff;

`ifndef SYNTHESIS
   a_stall_holds_valids: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("valid bits moved during an output stall");

   a_degenerate_result: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.degenerate_tri |->
         rsp_if.distortion == ONE_Q && !rsp_if.flipped_map)
      else $error("degenerate item without unit distortion");

   a_flip_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.flipped_map |-> rsp_if.distortion == '1)
      else $error("flipped map without saturated distortion");

   a_ratio_at_least_one: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.distortion >= ONE_Q)
      else $error("distortion below one");
`endif

endmodule
